// ===== hdl/image_base_relocation_fixup_core_defines.svh =====
// Assertion helpers shared by the relocation fixup RTL.
`ifndef IMAGE_BASE_RELOCATION_FIXUP_CORE_DEFINES_SVH
`define IMAGE_BASE_RELOCATION_FIXUP_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define IBRF_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("relocation fixup check failed");

// Next-cycle implication, checked outside reset.
`define IBRF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("relocation fixup check failed");

`endif

// ===== hdl/ibrf_pkg.sv =====
package ibrf_pkg;

	// Relocation entry types
	localparam logic [3:0] TYPE_HIGH       = 4'd1;
	localparam logic [3:0] TYPE_LOW        = 4'd2;
	localparam logic [3:0] TYPE_HIGHLOW    = 4'd3;
	localparam logic [3:0] TYPE_THUMB_PAIR = 4'd7;
	localparam logic [3:0] TYPE_DIR64      = 4'd10;

	// Write length codes
	localparam logic [1:0] LEN_NONE  = 2'd0;
	localparam logic [1:0] LEN_TWO   = 2'd1;
	localparam logic [1:0] LEN_FOUR  = 2'd2;
	localparam logic [1:0] LEN_EIGHT = 2'd3;

	// Configuration register indexes
	localparam logic CFG_NEW_BASE      = 1'b0;
	localparam logic CFG_ORIGINAL_BASE = 1'b1;

	// Instruction bits of a MOVW/MOVT word that are not part of imm16
	localparam logic [31:0] THUMB_KEEP_MASK = 32'h8f00fbf0;

	typedef struct packed {
		logic [3:0]  entry_type;
		logic [11:0] page_offset;
		logic [31:0] page_address;
		logic [63:0] old_bytes;
	} req_t;

	typedef struct packed {
		logic [31:0] target_address;
		logic [63:0] new_bytes;
		logic [1:0]  write_length;
	} rsp_t;

	// Gather imm4:i:imm3:imm8 of a Thumb-2 MOVW/MOVT word
	function automatic logic [15:0] thumb_imm_get(input logic [31:0] w);
		return {w[3:0], w[10], w[30:28], w[23:16]};
	endfunction

	// Scatter a 16-bit immediate back into a Thumb-2 MOVW/MOVT word
	function automatic logic [31:0] thumb_imm_put(input logic [31:0] w,
			input logic [15:0] imm);
		logic [31:0] f;
		f = w & THUMB_KEEP_MASK;
		f[3:0]   = imm[15:12];
		f[10]    = imm[11];
		f[30:28] = imm[10:8];
		f[23:16] = imm[7:0];
		return f;
	endfunction

endpackage

// ===== hdl/image_base_relocation_fixup_core.sv =====
// A request accepted on start passes the stage 1, stage 2 and stage 3 registers before result_valid rises.
// Throughput: one request per cycle; busy stays low and the pipeline never stalls.
// The stages are gather/target add, the 64-bit delta add, then type select and scatter.
// Reset clears both base registers, the delta register and all stage valid bits.
// A base write takes effect for requests started in the following cycle or later.
`include "image_base_relocation_fixup_core_defines.svh"

module image_base_relocation_fixup_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  ibrf_pkg::req_t request,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic           cfg_index,
	input  logic [63:0]    cfg_data,
	output logic           result_valid,
	output ibrf_pkg::rsp_t result
);

	logic        accept;
	logic [63:0] new_base_q;
	logic [63:0] original_base_q;
	logic [63:0] delta_q;

	logic        valid_s1;
	logic [3:0]  type_s1;
	logic [31:0] target_s1;
	logic [63:0] old_s1;
	logic [31:0] imm_s1;

	logic        valid_s2;
	logic [3:0]  type_s2;
	logic [31:0] target_s2;
	logic [63:0] old_s2;
	logic [63:0] sum_s2;
	logic [15:0] high_s2;
	logic [31:0] imm_s2;

	logic           valid_s3;
	ibrf_pkg::rsp_t rsp_s3;
	ibrf_pkg::rsp_t rsp_next;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// Hold base registers and precompute the delta
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			new_base_q      <= '0;
			original_base_q <= '0;
			delta_q         <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					ibrf_pkg::CFG_NEW_BASE:      new_base_q      <= cfg_data;
					ibrf_pkg::CFG_ORIGINAL_BASE: original_base_q <= cfg_data;
					default: ;
				endcase
			end
			delta_q <= new_base_q - original_base_q;
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Stage 1: target address and Thumb immediate gather
	always_ff @(posedge clk) begin
		type_s1   <= request.entry_type;
		target_s1 <= request.page_address + {20'd0, request.page_offset};
		old_s1    <= request.old_bytes;
		imm_s1    <= {ibrf_pkg::thumb_imm_get(request.old_bytes[63:32]),
			ibrf_pkg::thumb_imm_get(request.old_bytes[31:0])};
	end

	// Stage 2: add the delta to every candidate field
	always_ff @(posedge clk) begin
		type_s2   <= type_s1;
		target_s2 <= target_s1;
		old_s2    <= old_s1;
		sum_s2    <= old_s1 + delta_q;
		high_s2   <= old_s1[15:0] + delta_q[31:16];
		imm_s2    <= imm_s1 + delta_q[31:0];
	end

	// Stage 3: select the patched field by type
	always_comb begin
		rsp_next.target_address = target_s2;
		rsp_next.new_bytes      = old_s2;
		rsp_next.write_length   = ibrf_pkg::LEN_NONE;
		case (type_s2)
			ibrf_pkg::TYPE_HIGH: begin
				rsp_next.new_bytes    = {old_s2[63:16], high_s2};
				rsp_next.write_length = ibrf_pkg::LEN_TWO;
			end
			ibrf_pkg::TYPE_LOW: begin
				rsp_next.new_bytes    = {old_s2[63:16], sum_s2[15:0]};
				rsp_next.write_length = ibrf_pkg::LEN_TWO;
			end
			ibrf_pkg::TYPE_HIGHLOW: begin
				rsp_next.new_bytes    = {old_s2[63:32], sum_s2[31:0]};
				rsp_next.write_length = ibrf_pkg::LEN_FOUR;
			end
			ibrf_pkg::TYPE_THUMB_PAIR: begin
				rsp_next.new_bytes = {
					ibrf_pkg::thumb_imm_put(old_s2[63:32], imm_s2[31:16]),
					ibrf_pkg::thumb_imm_put(old_s2[31:0], imm_s2[15:0])};
				rsp_next.write_length = ibrf_pkg::LEN_EIGHT;
			end
			ibrf_pkg::TYPE_DIR64: begin
				rsp_next.new_bytes    = sum_s2;
				rsp_next.write_length = ibrf_pkg::LEN_EIGHT;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		rsp_s3 <= rsp_next;
	end

	assign result_valid = valid_s3;
	assign result       = rsp_s3;

	// Every request yields exactly one result_valid strobe once it leaves the pipeline registers
	`IBRF_ASSERT_NOW(a_strobe_follows, accept, ##3 result_valid)
	`IBRF_ASSERT_NOW(a_strobe_has_request, result_valid, $past(accept, 3))
	// Bytes beyond the write length keep the old contents
	`IBRF_ASSERT_NOW(a_two_keeps_upper,
		result_valid && result.write_length == ibrf_pkg::LEN_TWO,
		result.new_bytes[63:16] == $past(request.old_bytes[63:16], 3))
	`IBRF_ASSERT_NOW(a_four_keeps_upper,
		result_valid && result.write_length == ibrf_pkg::LEN_FOUR,
		result.new_bytes[63:32] == $past(request.old_bytes[63:32], 3))
	// The delta register follows the bases in the next cycle
	`IBRF_ASSERT_NEXT(a_delta_tracks, 1'b1,
		delta_q == $past(new_base_q) - $past(original_base_q))

endmodule
